// File: rtl/indexed_list_engine_defines.svh
// Assertion macros shared by the indexed list engine sources.
// Depends on nothing; the including module must provide clk and rst.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ILE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ILE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ile_pkg.sv
// Shared widths, operation and status codes, and types of the indexed list engine.
// Depends on nothing.
package ile_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int OP_W         = 3;
  localparam int POS_W        = 10;
  localparam int VAL_W        = 32;
  localparam int ST_W         = 2;
  localparam int LEN_W        = 9;
  localparam int TREE_FANIN   = 4;

  localparam logic [OP_W-1:0] OP_GET  = OP_W'(0);
  localparam logic [OP_W-1:0] OP_HEAD = OP_W'(1);
  localparam logic [OP_W-1:0] OP_TAIL = OP_W'(2);
  localparam logic [OP_W-1:0] OP_AT   = OP_W'(3);
  localparam logic [OP_W-1:0] OP_DEL  = OP_W'(4);

  localparam logic [ST_W-1:0] ST_DONE  = ST_W'(0);
  localparam logic [ST_W-1:0] ST_RANGE = ST_W'(1);
  localparam logic [ST_W-1:0] ST_FULL  = ST_W'(2);

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] length;
  } result_t;

  // Broadcast shift command for the row of cells.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

  // Number of registered levels of a four-way tree that covers n leaves.
  function automatic int tree_levels(input int n);
    int lv;
    int span;
    begin
      lv   = 1;
      span = TREE_FANIN;
      while (span < n) begin
        lv   = lv + 1;
        span = span * TREE_FANIN;
      end
      return lv;
    end
  endfunction

endpackage

// File: rtl/ile_if.sv
// Valid/ready channel interfaces for operations in and results out.
// Depends on ile_pkg for the field widths.
interface ile_in_if;
  import ile_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [POS_W-1:0] position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, operation, position, item_value, input ready);
  modport sink   (input valid, operation, position, item_value, output ready);
endinterface

interface ile_out_if;
  import ile_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [ST_W-1:0]         status;
  logic [LEN_W-1:0]        length;

  modport source (output valid, read_value, status, length, input ready);
  modport sink   (input valid, read_value, status, length, output ready);
endinterface

// File: rtl/ile_cell.sv
// One storage cell of the list: holds one entry and shifts with its neighbors.
// Depends on ile_pkg for the command type and value width.
module ile_cell #(
  parameter int IDXW  = 8,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  ile_pkg::cell_cmd_t       cmd,
  input  logic [IDXW-1:0]          pos,
  input  logic [ile_pkg::VAL_W-1:0] new_value,
  input  logic [ile_pkg::VAL_W-1:0] left_value,
  input  logic [ile_pkg::VAL_W-1:0] right_value,
  input  logic [IDXW-1:0]          rd_pos,
  output logic [ile_pkg::VAL_W-1:0] value,
  output logic [ile_pkg::VAL_W-1:0] rd_value
);
  import ile_pkg::*;

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);

  // Insert: the target cell loads the new value and every later cell takes its
  // left neighbor. Delete: the target cell and every later one take the right.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (pos == MY_IDX) begin
        value <= new_value;
      end else if (MY_IDX > pos) begin
        value <= left_value;
      end
    end else if (cmd.del && (MY_IDX >= pos)) begin
      value <= right_value;
    end
  end

  assign rd_value = (rd_pos == MY_IDX) ? value : '0;

endmodule

// File: rtl/ile_rd_tree.sv
// Registered four-way OR tree that gathers the one selected cell value.
// Depends on ile_pkg for the value width, fan-in and level count.
module ile_rd_tree #(
  parameter int N = 256
) (
  input  logic                      clk,
  input  logic [ile_pkg::VAL_W-1:0] leaf [N],
  output logic [ile_pkg::VAL_W-1:0] root
);
  import ile_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int PAD    = TREE_FANIN ** LEVELS;
  localparam int NODES  = (PAD - 1) / (TREE_FANIN - 1);

  // Heap order: node k has children FANIN*k+1 .. FANIN*k+FANIN; indexes past
  // the internal nodes are leaves, and padding leaves read as zero.
  logic [VAL_W-1:0] node [NODES];

  for (genvar k = 0; k < NODES; k++) begin : g_node
    logic [VAL_W-1:0] kid [TREE_FANIN];
    for (genvar j = 0; j < TREE_FANIN; j++) begin : g_kid
      localparam int C = TREE_FANIN * k + 1 + j;
      if (C < NODES) begin : g_int
        assign kid[j] = node[C];
      end else if (C - NODES < N) begin : g_leaf
        assign kid[j] = leaf[C - NODES];
      end else begin : g_pad
        assign kid[j] = '0;
      end
    end

    always_ff @(posedge clk) begin
      node[k] <= kid[0] | kid[1] | kid[2] | kid[3];
    end
  end

  assign root = node[0];

endmodule

// File: rtl/indexed_list_engine.sv
// Top level of the indexed list engine: a row of shifting cells, a read tree
// and the operation control. Depends on ile_pkg, ile_if, ile_cell, ile_rd_tree.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit values in a
// row of cells, one value per cell. Every transfer on the items channel is one
// operation and gives exactly one transfer on the results channel, in order.
// Inserts and deletes move all later entries by one place in the same clock,
// so add at head, add at tail, add at position, delete and a get at an
// invalid position are accepted at one per cycle while the results channel
// keeps up. A get at a valid position gathers the selected cell through a
// registered four-way OR tree of ceil(log4(CAPACITY)) levels. No operation
// is accepted during the read; its result enters the output register, or
// the spare slot, once the read counter reaches the tree depth. A result is
// held in an output register backed by one spare slot, so one more
// operation is taken while a result waits. Cell contents have no reset;
// only entries below the current length are ever read. The length field
// reports the count after each operation, masked to nine bits.
`include "indexed_list_engine_defines.svh"

module indexed_list_engine #(
  parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  ile_in_if.sink   items,
  ile_out_if.source results
);
  import ile_pkg::*;

  localparam int IDXW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW   = $clog2(CAPACITY + 1);
  localparam int CMPW   = (CNTW > POS_W - 1) ? CNTW : POS_W - 1;
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int CYW    = $clog2(LEVELS + 1);

  typedef enum logic {
    IDLE,
    READ
  } state_t;

  state_t           state;
  logic [CNTW-1:0]  count;
  logic [CNTW-1:0]  count_next;
  logic [CYW-1:0]   cyc;
  logic [IDXW-1:0]  rd_pos;
  result_t          out_res;
  result_t          hold_res;
  logic             out_vld;
  logic             hold_vld;

  logic             accept;
  logic             pos_neg;
  logic [CMPW-1:0]  pos_cmp;
  logic [CMPW-1:0]  cnt_cmp;
  logic [CMPW-1:0]  at_cmp;
  logic             in_range;
  logic             full;
  logic             start_rd;
  cell_cmd_t        op_cmd;
  cell_cmd_t        cell_cmd;
  logic [IDXW-1:0]  shift_pos;
  result_t          imm_res;
  result_t          prod_res;
  logic             prod;

  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [VAL_W-1:0] rd_leaf  [CAPACITY];
  logic [VAL_W-1:0] tree_root;

  assign items.ready = (state == IDLE) && !hold_vld;
  assign accept      = items.valid && items.ready;

  // Position checks. A negative position has its sign bit set; the magnitude
  // bits are compared against the count at a common width.
  assign pos_neg  = items.position[POS_W-1];
  assign pos_cmp  = CMPW'(items.position[POS_W-2:0]);
  assign cnt_cmp  = CMPW'(count);
  assign in_range = !pos_neg && (pos_cmp < cnt_cmp);
  assign at_cmp   = pos_neg ? '0 : pos_cmp;
  assign full     = count >= CNTW'(CAPACITY);

  // Decode of the operation offered on the items channel. An insert into a
  // full list and a position past the end leave the cells untouched; for add
  // at position the range check takes precedence over the full check.
  always_comb begin
    op_cmd             = '0;
    shift_pos          = '0;
    count_next         = count;
    start_rd           = 1'b0;
    imm_res.read_value = '0;
    imm_res.status     = ST_DONE;
    case (items.operation)
      OP_GET: begin
        if (in_range) begin
          start_rd = 1'b1;
        end else begin
          imm_res.read_value = '1;
          imm_res.status     = ST_RANGE;
        end
      end
      OP_HEAD: begin
        if (full) begin
          imm_res.status = ST_FULL;
        end else begin
          op_cmd.ins = 1'b1;
          count_next = CNTW'(count + 1'b1);
        end
      end
      OP_TAIL: begin
        if (full) begin
          imm_res.status = ST_FULL;
        end else begin
          op_cmd.ins = 1'b1;
          shift_pos  = IDXW'(count);
          count_next = CNTW'(count + 1'b1);
        end
      end
      OP_AT: begin
        if (at_cmp > cnt_cmp) begin
          imm_res.status = ST_RANGE;
        end else if (full) begin
          imm_res.status = ST_FULL;
        end else begin
          op_cmd.ins = 1'b1;
          shift_pos  = IDXW'(at_cmp);
          count_next = CNTW'(count + 1'b1);
        end
      end
      OP_DEL: begin
        if (in_range) begin
          op_cmd.del = 1'b1;
          shift_pos  = IDXW'(pos_cmp);
          count_next = CNTW'(count - 1'b1);
        end else begin
          imm_res.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    imm_res.length = LEN_W'(count_next);
  end

  assign cell_cmd = accept ? op_cmd : '0;

  // A result is produced either at the transfer of an operation that needs no
  // read, or when the read tree output has settled for a get.
  assign prod = (accept && !start_rd) || ((state == READ) && (cyc == CYW'(LEVELS)));

  always_comb begin
    if (state == READ) begin
      prod_res.read_value = tree_root;
      prod_res.status     = ST_DONE;
      prod_res.length     = LEN_W'(count);
    end else begin
      prod_res = imm_res;
    end
  end

  // Control state, count and the two result slots. The spare slot only fills
  // when the output register is occupied and not being taken. A new result
  // never arrives while the spare slot is occupied, since the items channel
  // is closed then and no read is in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      cyc      <= '0;
      out_vld  <= 1'b0;
      hold_vld <= 1'b0;
    end else begin
      if (prod) begin
        if (!out_vld || results.ready) begin
          out_res <= prod_res;
          out_vld <= 1'b1;
        end else begin
          hold_res <= prod_res;
          hold_vld <= 1'b1;
        end
      end else if (out_vld && results.ready) begin
        if (hold_vld) begin
          out_res  <= hold_res;
          hold_vld <= 1'b0;
        end else begin
          out_vld <= 1'b0;
        end
      end
      if (accept) begin
        count <= count_next;
      end
      case (state)
        IDLE: begin
          if (accept && start_rd) begin
            state  <= READ;
            cyc    <= '0;
            rd_pos <= IDXW'(pos_cmp);
          end
        end
        READ: begin
          if (cyc == CYW'(LEVELS)) begin
            state <= IDLE;
          end else begin
            cyc <= CYW'(cyc + 1'b1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign results.valid      = out_vld;
  assign results.read_value = out_res.read_value;
  assign results.status     = out_res.status;
  assign results.length     = out_res.length;

  // The row of cells. The first cell never takes a left neighbor and the last
  // cell shifts in a don't-care value beyond the end of the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = items.item_value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    ile_cell #(
      .IDXW  (IDXW),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .pos         (shift_pos),
      .new_value   (items.item_value),
      .left_value  (left_v),
      .right_value (right_v),
      .rd_pos      (rd_pos),
      .value       (cell_val[i]),
      .rd_value    (rd_leaf[i])
    );
  end

  ile_rd_tree #(
    .N (CAPACITY)
  ) u_rd_tree (
    .clk  (clk),
    .leaf (rd_leaf),
    .root (tree_root)
  );

  // The count never passes the capacity of the row.
  `ILE_ASSERT_IMP(a_count_cap, 1'b1, count <= CNTW'(CAPACITY), "count above capacity")
  // The spare slot is only in use behind a waiting output register.
  `ILE_ASSERT_IMP(a_hold_behind_out, hold_vld, out_vld, "spare slot full with output empty")
  // An insert that reaches the cells grows the list by exactly one.
  `ILE_ASSERT_NXT(a_ins_grows, cell_cmd.ins, count == CNTW'($past(count) + 1'b1), "insert count")
  // A delete that reaches the cells shrinks the list by exactly one.
  `ILE_ASSERT_NXT(a_del_shrinks, cell_cmd.del, count == CNTW'($past(count) - 1'b1), "delete count")

endmodule

// File: bench/tb.sv
// Self-checking testbench for the indexed list engine: directed operations, then
// random operation streams, checked against an in-bench list predictor.
// Depends on ile_pkg, the ile_in_if/ile_out_if interfaces and indexed_list_engine.
module tb;
  import ile_pkg::*;

  localparam int LIST_CAPACITY  = CAPACITY_DEF;
  localparam int MAX_GAP        = 11;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 25;

  // Operation codes the engine must treat as no-ops.
  localparam logic [OP_W-1:0] OP_SPARE_A = OP_W'(5);
  localparam logic [OP_W-1:0] OP_SPARE_B = OP_W'(6);
  localparam logic [OP_W-1:0] OP_SPARE_C = OP_W'(7);

  // One row of the directed script. When hand_checked is set, the result
  // fields of the row are the outcome that the engine must give; otherwise
  // the predictor supplies the outcome.
  typedef struct {
    logic [OP_W-1:0] op;
    int              pos;
    int              val;
    bit              hand_checked;
    int              read_value;
    logic [ST_W-1:0] status;
    int              length;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;

  ile_in_if  items_ch ();
  ile_out_if results_ch ();

  indexed_list_engine dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // Shadow copy of the list, kept in step with every accepted operation.
  logic [VAL_W-1:0] list_copy [LIST_CAPACITY];
  int               list_count = 0;

  // Outcomes of accepted operations whose result transfer has not come yet.
  result_t pending_outcomes [$];

  // Hand-written outcome for the operation currently offered, if any.
  bit      typed_check = 1'b0;
  result_t typed_outcome;

  int      mismatches  = 0;
  int      idle_cycles = 0;
  bit      sender_eager = 1'b0;
  bit      sink_eager   = 1'b0;
  result_t observed;
  result_t awaited;

  directed_row_t directed_rows [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Insert v so that it lands at index at; later entries move up by one.
  // A full list is checked first, then the position.
  function automatic logic [ST_W-1:0] insert_value(input int at, input logic [VAL_W-1:0] v);
    int i;
    if (list_count >= LIST_CAPACITY) return ST_FULL;
    if (at > list_count) return ST_RANGE;
    for (i = list_count; i > at; i--) list_copy[i] = list_copy[i-1];
    list_copy[at] = v;
    list_count++;
    return ST_DONE;
  endfunction

  // Apply one operation to the shadow list and return the result it must give.
  function automatic result_t list_op_outcome(input logic [OP_W-1:0] op,
                                              input logic signed [POS_W-1:0] pos,
                                              input logic [VAL_W-1:0] v);
    result_t r;
    int      p;
    int      i;
    bit      in_range;
    p          = pos;
    in_range   = (p >= 0) && (p < list_count);
    r.read_value = '0;
    r.status     = ST_DONE;
    case (op)
      OP_GET: begin
        if (in_range) begin
          r.read_value = list_copy[p];
        end else begin
          r.read_value = '1;
          r.status     = ST_RANGE;
        end
      end
      OP_HEAD: r.status = insert_value(0, v);
      OP_TAIL: r.status = insert_value(list_count, v);
      OP_AT: begin
        // A negative position clamps to the head; a position past the end is
        // rejected before the full check can be reached.
        if (p < 0) p = 0;
        if (p > list_count) r.status = ST_RANGE;
        else r.status = insert_value(p, v);
      end
      OP_DEL: begin
        if (in_range) begin
          for (i = p; i < list_count - 1; i++) list_copy[i] = list_copy[i+1];
          list_count--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(list_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch (%s): want %0d/%0d/%0d got %0d/%0d/%0d",
               what, $signed(want.read_value), want.status, want.length,
               $signed(got.read_value), got.status, got.length);
  endtask

  // Result checker and predictor hook. The result side is handled first; a
  // result can never belong to an operation accepted at the same edge, since
  // the engine registers its output.
  always @(posedge clk) begin
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) begin
        observed.read_value = results_ch.read_value;
        observed.status     = results_ch.status;
        observed.length     = results_ch.length;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with nothing pending", '0, observed);
        end else begin
          awaited = pending_outcomes.pop_front();
          if (observed.read_value !== awaited.read_value ||
              observed.status !== awaited.status ||
              observed.length !== awaited.length)
            report_mismatch("field", awaited, observed);
        end
      end
      if (items_ch.valid && items_ch.ready) begin
        // The predictor always runs so that the shadow list stays current,
        // even on rows whose outcome was written by hand.
        awaited = list_op_outcome(items_ch.operation, items_ch.position, items_ch.item_value);
        pending_outcomes.push_back(typed_check ? typed_outcome : awaited);
      end
    end
  end

  // Watchdog: count cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[indexed_list_engine] ERROR");
    $finish;
  end

  // Result sink. Before each transfer it draws a random stall, which may be zero,
  // and holds ready low for it, except during eager stretches where ready stays high throughout.
  initial begin : result_sink
    int stall;
    results_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 24) == 0) sink_eager = !sink_eager;
      stall = sink_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        results_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_ch.ready <= 1'b1;
      do @(posedge clk); while (!(results_ch.valid && results_ch.ready));
      @(negedge clk);
    end
  end

  // Offer one operation and hold it until the transfer happens. The task is
  // entered and left at a falling edge; valid is left high so that a
  // back-to-back operation never lowers and raises it in one time step.
  task automatic send_op(input logic [OP_W-1:0] op, input int pos, input int val,
                         input bit hand_checked, input result_t want);
    int gap;
    if ($urandom_range(0, 24) == 0) sender_eager = !sender_eager;
    gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_check   = hand_checked;
    typed_outcome = want;
    items_ch.operation  <= op;
    items_ch.position   <= pos[POS_W-1:0];
    items_ch.item_value <= val;
    items_ch.valid      <= 1'b1;
    do @(posedge clk); while (!(items_ch.valid && items_ch.ready));
    @(negedge clk);
  endtask

  // Random operation. insert_pct sets the share of the three insert kinds;
  // the rest splits between get, delete and the spare codes. Positions lean
  // toward the live part of the list, with full-range and edge values mixed in.
  task automatic send_random(input int insert_pct);
    logic [OP_W-1:0] op;
    int              pos;
    int              val;
    int              r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) begin
      case ($urandom_range(0, 2))
        0:       op = OP_HEAD;
        1:       op = OP_TAIL;
        default: op = OP_AT;
      endcase
    end else begin
      r = $urandom_range(0, 19);
      if (r < 9) op = OP_GET;
      else if (r < 18) op = OP_DEL;
      else begin
        case ($urandom_range(0, 2))
          0:       op = OP_SPARE_A;
          1:       op = OP_SPARE_B;
          default: op = OP_SPARE_C;
        endcase
      end
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      pos = $urandom_range(0, list_count);
    end else if (r < 85) begin
      pos = $signed(POS_W'($urandom));
    end else begin
      case ($urandom_range(0, 4))
        0:       pos = -1;
        1:       pos = list_count;
        2:       pos = list_count + 1;
        3:       pos = -512;
        default: pos = 511;
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       val = 0;
        1:       val = -1;
        2:       val = 32'h7FFF_FFFF;
        default: val = 32'h8000_0000;
      endcase
    end else begin
      val = $urandom;
    end
    send_op(op, pos, val, 1'b0, '0);
  endtask

  initial begin : stimulus
    result_t want;
    items_ch.valid      = 1'b0;
    items_ch.operation  = OP_GET;
    items_ch.position   = '0;
    items_ch.item_value = '0;

    // Directed script. It starts on the empty list, builds five entries
    // with the value extremes, then probes bad positions, the spare codes
    // and deletes at both ends of the valid range.
    directed_rows = '{
      '{OP_GET,     0,    0,            1'b1, -1,           ST_RANGE, 0},
      '{OP_DEL,     0,    0,            1'b1, 0,            ST_RANGE, 0},
      '{OP_AT,      1,    0,            1'b1, 0,            ST_RANGE, 0},
      '{OP_AT,      -512, 32'h7FFF_FFFF, 1'b1, 0,           ST_DONE,  1},
      '{OP_HEAD,    0,    32'h8000_0000, 1'b1, 0,           ST_DONE,  2},
      '{OP_TAIL,    511,  -1,           1'b1, 0,            ST_DONE,  3},
      '{OP_AT,      3,    32'h5555_5555, 1'b1, 0,           ST_DONE,  4},
      '{OP_AT,      1,    32'hAAAA_AAAA, 1'b0, 0,           ST_DONE,  0},
      '{OP_GET,     0,    0,            1'b1, 32'h8000_0000, ST_DONE, 5},
      '{OP_GET,     1,    0,            1'b0, 0,            ST_DONE,  0},
      '{OP_GET,     4,    0,            1'b0, 0,            ST_DONE,  0},
      '{OP_GET,     5,    0,            1'b1, -1,           ST_RANGE, 5},
      '{OP_GET,     -1,   0,            1'b1, -1,           ST_RANGE, 5},
      '{OP_GET,     511,  0,            1'b1, -1,           ST_RANGE, 5},
      '{OP_GET,     -512, 0,            1'b1, -1,           ST_RANGE, 5},
      '{OP_SPARE_A, 0,    -1,           1'b1, 0,            ST_DONE,  5},
      '{OP_SPARE_B, 2,    -1,           1'b1, 0,            ST_DONE,  5},
      '{OP_SPARE_C, -1,   -1,           1'b1, 0,            ST_DONE,  5},
      '{OP_AT,      511,  1,            1'b1, 0,            ST_RANGE, 5},
      '{OP_AT,      6,    1,            1'b1, 0,            ST_RANGE, 5},
      '{OP_DEL,     5,    0,            1'b1, 0,            ST_RANGE, 5},
      '{OP_DEL,     -1,   0,            1'b1, 0,            ST_RANGE, 5},
      '{OP_DEL,     1,    0,            1'b0, 0,            ST_DONE,  0},
      '{OP_DEL,     0,    0,            1'b0, 0,            ST_DONE,  0},
      '{OP_GET,     0,    0,            1'b0, 0,            ST_DONE,  0}
    };

    // Synchronous reset, released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      want.read_value = directed_rows[k].read_value;
      want.status     = directed_rows[k].status;
      want.length     = LEN_W'(directed_rows[k].length);
      send_op(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
              directed_rows[k].hand_checked, want);
    end

    // Mixed traffic on a short list.
    repeat (120) send_random(55);

    // Hold the sender back until the engine has returned every result.
    items_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);

    // Fill the list to capacity, then work at the full boundary where
    // inserts are dropped and deletes reopen single slots.
    while (list_count < LIST_CAPACITY) send_random(100);
    repeat (40) send_random(70);

    // Delete-heavy traffic on a long list.
    repeat (120) send_random(30);

    items_ch.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("[indexed_list_engine] OK");
    end else begin
      $display("[indexed_list_engine] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ile_pkg.sv
rtl/ile_if.sv
rtl/ile_cell.sv
rtl/ile_rd_tree.sv
rtl/indexed_list_engine.sv
bench/tb.sv
